@@ hdl/rrtp_pkg.sv @@
package rrtp_pkg;

  // Request kinds carried in tuser of the input channel
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_PICK   = 2'd2;

  // Result codes carried in tuser of the output channel
  localparam logic [2:0] RC_PICKED = 3'd0;
  localparam logic [2:0] RC_IDLE   = 3'd1;
  localparam logic [2:0] RC_ALARM  = 3'd2;
  localparam logic [2:0] RC_ACK    = 3'd3;
  localparam logic [2:0] RC_ERROR  = 3'd4;

  // Thread run states
  localparam logic [2:0] RS_RUNNABLE   = 3'd0;
  localparam logic [2:0] RS_SYSCALL    = 3'd1;
  localparam logic [2:0] RS_BLOCKED    = 3'd2;
  localparam logic [2:0] RS_SYS_BLOCK  = 3'd3;

  // Width of a semaphore index compare against the semaphore count
  localparam int SEMA_CMP_W = 7;

  // One slot table entry; wait_code bit 4 = waiting, bits 3..0 = semaphore
  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  wait_code;
    logic [31:0] alarm;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

@@ hdl/rrtp_ram.sv @@
module rrtp_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/round_robin_thread_picker.sv @@
// Round-robin thread picker. Keeps a table of MAX_SLOTS thread slots (run
// state, alarm tick, optional semaphore wait) in a single RAM with a
// registered read port. Requests arrive on the in_ stream, the kind in
// in_tuser: add appends a slot, update rewrites one, pick walks the table
// round-robin from the slot after the last pick, fires expired alarms on the
// way (alarm != 0 and alarm <= now_tick), wakes blocked slots whose semaphore
// is flagged in sema_ready_mask, and stops at the first runnable slot or
// reports idle after one full circle. Each request yields one or more
// results on the out_ stream; out_tlast marks the final result of a request.
// An add or update goes from accept to a pending result and from there into
// the output register. A pick reads the RAM for each visited slot, then
// evaluates it on the shared alarm comparator, and passes each result
// through the output register. One request is in flight at a time; in_tready
// drops from accept until the last result is loaded into the output
// register. The slot table is not cleared at reset: a slot is read only
// after an add has written it.
module round_robin_thread_picker
  import rrtp_pkg::*;
#(
  parameter int MAX_SLOTS = 16,
  parameter int NUM_SEMAS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, low bit up: slot_index[3:0], run_state[6:4], waits_on_sema[7],
  // sema_index[11:8], alarm_time[43:12], now_tick[75:44],
  // sema_ready_mask[91:76], zero fill
  input  logic [95:0] in_tdata,
  // in_tuser: kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, low bit up: out_slot[3:0], fired_alarm_time[35:4],
  // out_run_state[38:36], zero fill
  output logic [39:0] out_tdata,
  // out_tuser: result_code[2:0]
  output logic [2:0]  out_tuser,
  // out_tlast: last_of_run
  output logic        out_tlast
);

  localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EVAL = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  // What follows once the pending result is taken
  typedef enum logic [1:0] {
    POST_NONE = 2'd0,
    POST_PICK = 2'd1,
    POST_ADV  = 2'd2
  } post_t;

  // Unpack the request
  logic [3:0]  req_slot;
  logic [2:0]  req_rs;
  logic        req_waits;
  logic [3:0]  req_sema;
  logic [31:0] req_alarm;
  logic [31:0] req_now;
  logic [15:0] req_mask;

  assign req_slot  = in_tdata[3:0];
  assign req_rs    = in_tdata[6:4];
  assign req_waits = in_tdata[7];
  assign req_sema  = in_tdata[11:8];
  assign req_alarm = in_tdata[43:12];
  assign req_now   = in_tdata[75:44];
  assign req_mask  = in_tdata[91:76];

  state_t          state_r, state_nxt;
  post_t           post_r, post_nxt;
  logic [CW-1:0]   slot_count_r, slot_count_nxt;
  logic [SW-1:0]   last_pick_r, last_pick_nxt;
  logic            lp_valid_r, lp_valid_nxt;
  logic [SW-1:0]   cur_r, cur_nxt;
  logic [CW-1:0]   vis_r, vis_nxt;
  logic [31:0]     now_r, now_nxt;
  logic [15:0]     mask_r, mask_nxt;
  logic [2:0]      pick_rs_r, pick_rs_nxt;

  // Pending result
  logic [2:0]      rsp_code_r, rsp_code_nxt;
  logic [3:0]      rsp_slot_r, rsp_slot_nxt;
  logic [31:0]     rsp_alarm_r, rsp_alarm_nxt;
  logic [2:0]      rsp_rs_r, rsp_rs_nxt;
  logic            rsp_last_r, rsp_last_nxt;

  // Output register
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [39:0]     out_tdata_r, out_tdata_nxt;
  logic [2:0]      out_tuser_r, out_tuser_nxt;
  logic            out_tlast_r, out_tlast_nxt;
  logic            out_free;

  // Slot table
  logic            ram_we;
  logic [SW-1:0]   ram_waddr;
  slot_entry_t     ram_wentry;
  logic [ENTRY_W-1:0] ram_rdata;
  slot_entry_t     ent;

  // Walk helpers
  logic [CW-1:0]   lp_inc;
  logic [SW-1:0]   start_cur;
  logic            walk_done;
  logic            fire;
  logic            runnable;
  logic            blocked;
  logic            sema_ok;
  logic            wake;
  logic [2:0]      woken_st;
  logic [2:0]      stop_rs;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  rrtp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (cur_r),
    .rdata (ram_rdata)
  );

  assign ent = slot_entry_t'(ram_rdata);

  // Next slot of the circle: wrap to zero at the fill mark or before any pick
  assign lp_inc    = CW'(last_pick_r) + CW'(1);
  assign start_cur = (!lp_valid_r || (lp_inc >= slot_count_r)) ? '0 : SW'(lp_inc);
  assign walk_done = (vis_r >= slot_count_r);

  // Shared compare unit: alarm against the current tick, one slot per pass
  assign fire     = (ent.alarm != 32'd0) && (ent.alarm <= now_r);
  assign runnable = (ent.status == RS_RUNNABLE) || (ent.status == RS_SYSCALL);
  assign blocked  = (ent.status == RS_BLOCKED) || (ent.status == RS_SYS_BLOCK);
  // A semaphore index at or beyond the configured count never reads as ready
  assign sema_ok  = (SEMA_CMP_W'(ent.wait_code[3:0]) < SEMA_CMP_W'(NUM_SEMAS)) &&
                    mask_r[ent.wait_code[3:0]];
  assign wake     = blocked && ent.wait_code[4] && sema_ok;
  assign woken_st = (ent.status == RS_BLOCKED) ? RS_RUNNABLE : RS_SYSCALL;
  assign stop_rs  = wake ? woken_st : ent.status;

  always_comb begin
    state_nxt      = state_r;
    post_nxt       = post_r;
    slot_count_nxt = slot_count_r;
    last_pick_nxt  = last_pick_r;
    lp_valid_nxt   = lp_valid_r;
    cur_nxt        = cur_r;
    vis_nxt        = vis_r;
    now_nxt        = now_r;
    mask_nxt       = mask_r;
    pick_rs_nxt    = pick_rs_r;
    rsp_code_nxt   = rsp_code_r;
    rsp_slot_nxt   = rsp_slot_r;
    rsp_alarm_nxt  = rsp_alarm_r;
    rsp_rs_nxt     = rsp_rs_r;
    rsp_last_nxt   = rsp_last_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    ram_we         = 1'b0;
    ram_waddr      = SW'(slot_count_r);
    ram_wentry     = '{status: req_rs, wait_code: {req_waits, req_sema}, alarm: req_alarm};

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          now_nxt       = req_now;
          mask_nxt      = req_mask;
          post_nxt      = POST_NONE;
          rsp_code_nxt  = RC_ERROR;
          rsp_slot_nxt  = '0;
          rsp_alarm_nxt = '0;
          rsp_rs_nxt    = '0;
          rsp_last_nxt  = 1'b1;
          state_nxt     = S_RESP;
          case (in_tuser)
            KIND_ADD: begin
              if (slot_count_r < CW'(MAX_SLOTS)) begin
                ram_we         = 1'b1;
                ram_waddr      = SW'(slot_count_r);
                rsp_code_nxt   = RC_ACK;
                rsp_slot_nxt   = 4'(slot_count_r);
                slot_count_nxt = slot_count_r + CW'(1);
              end
            end
            KIND_UPDATE: begin
              if (CMPW'(req_slot) < CMPW'(slot_count_r)) begin
                ram_we       = 1'b1;
                ram_waddr    = SW'(req_slot);
                rsp_code_nxt = RC_ACK;
                rsp_slot_nxt = req_slot;
              end
            end
            KIND_PICK: begin
              if (slot_count_r != '0) begin
                cur_nxt       = start_cur;
                last_pick_nxt = start_cur;
                lp_valid_nxt  = 1'b1;
                vis_nxt       = CW'(1);
                state_nxt     = S_RD;
              end
            end
            default: begin
              rsp_code_nxt = RC_ERROR;
            end
          endcase
        end
      end

      S_RD: begin
        // RAM read of cur_r is under way
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        // Write back a cleared alarm and any wake-up in one go
        if (fire || wake) begin
          ram_we     = 1'b1;
          ram_waddr  = cur_r;
          ram_wentry = '{status:    stop_rs,
                         wait_code: wake ? 5'd0 : ent.wait_code,
                         alarm:     fire ? 32'd0 : ent.alarm};
        end
        pick_rs_nxt = stop_rs;
        if (fire) begin
          rsp_code_nxt  = RC_ALARM;
          rsp_slot_nxt  = 4'(cur_r);
          rsp_alarm_nxt = ent.alarm;
          rsp_rs_nxt    = '0;
          rsp_last_nxt  = 1'b0;
          post_nxt      = (runnable || wake) ? POST_PICK : POST_ADV;
          state_nxt     = S_RESP;
        end else if (runnable || wake) begin
          rsp_code_nxt  = RC_PICKED;
          rsp_slot_nxt  = 4'(cur_r);
          rsp_alarm_nxt = '0;
          rsp_rs_nxt    = stop_rs;
          rsp_last_nxt  = 1'b1;
          post_nxt      = POST_NONE;
          state_nxt     = S_RESP;
        end else if (walk_done) begin
          rsp_code_nxt  = RC_IDLE;
          rsp_slot_nxt  = '0;
          rsp_alarm_nxt = '0;
          rsp_rs_nxt    = '0;
          rsp_last_nxt  = 1'b1;
          post_nxt      = POST_NONE;
          state_nxt     = S_RESP;
        end else begin
          cur_nxt       = start_cur;
          last_pick_nxt = start_cur;
          vis_nxt       = vis_r + CW'(1);
          state_nxt     = S_RD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, rsp_rs_r, rsp_alarm_r, rsp_slot_r};
          out_tuser_nxt  = rsp_code_r;
          out_tlast_nxt  = rsp_last_r;
          case (post_r)
            POST_PICK: begin
              rsp_code_nxt  = RC_PICKED;
              rsp_slot_nxt  = 4'(cur_r);
              rsp_alarm_nxt = '0;
              rsp_rs_nxt    = pick_rs_r;
              rsp_last_nxt  = 1'b1;
              post_nxt      = POST_NONE;
            end
            POST_ADV: begin
              if (walk_done) begin
                rsp_code_nxt  = RC_IDLE;
                rsp_slot_nxt  = '0;
                rsp_alarm_nxt = '0;
                rsp_rs_nxt    = '0;
                rsp_last_nxt  = 1'b1;
                post_nxt      = POST_NONE;
              end else begin
                cur_nxt       = start_cur;
                last_pick_nxt = start_cur;
                vis_nxt       = vis_r + CW'(1);
                state_nxt     = S_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      post_r       <= POST_NONE;
      slot_count_r <= '0;
      last_pick_r  <= '0;
      lp_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      post_r       <= post_nxt;
      slot_count_r <= slot_count_nxt;
      last_pick_r  <= last_pick_nxt;
      lp_valid_r   <= lp_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    vis_r       <= vis_nxt;
    now_r       <= now_nxt;
    mask_r      <= mask_nxt;
    pick_rs_r   <= pick_rs_nxt;
    rsp_code_r  <= rsp_code_nxt;
    rsp_slot_r  <= rsp_slot_nxt;
    rsp_alarm_r <= rsp_alarm_nxt;
    rsp_rs_r    <= rsp_rs_nxt;
    rsp_last_r  <= rsp_last_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  // A walk never visits more slots than the table holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> ((vis_r != '0) && (vis_r <= slot_count_r) && lp_valid_r))
    else $error("pick walk visit count out of range");

  // An alarm result is always followed by another result of the same request
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tuser_r == RC_ALARM)) |-> !out_tlast_r)
    else $error("alarm result marked last");

  // Pick, idle, ack and error results close their request
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tuser_r != RC_ALARM)) |-> out_tlast_r)
    else $error("closing result not marked last");

  // A walk never goes from evaluating a slot straight back to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |=> (state_r != S_IDLE))
    else $error("walk returned to idle without a result");

endmodule
